/* design/utf8_to_utf16_decoder_core_macros.svh */
// Assertion macros shared by the checker of the UTF-8 to UTF-16 decoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH

// Assertion that is switched off while reset is held.
`define U8U16_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is held.
`define U8U16_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/u8u16_pkg.sv */
// Types and constants of the UTF-8 to UTF-16 decoder.
// No dependencies; used by the decode step and the top level.
package u8u16_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned UNIT_W    = 16;
  localparam int unsigned PARTIAL_W = 10;
  localparam int unsigned EXPECT_W  = 2;

  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hc0;
  localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'he0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hc0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hf0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'he0;
  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1f;
  localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0f;
  localparam logic [BYTE_W-1:0] CONT_DATA  = 8'h3f;

  localparam logic [EXPECT_W-1:0] EXP_NONE = 2'd0;
  localparam logic [EXPECT_W-1:0] EXP_ONE  = 2'd1;
  localparam logic [EXPECT_W-1:0] EXP_TWO  = 2'd2;

  // Outcome of decoding one byte against the current sequence state.
  typedef struct packed {
    logic                 emit;
    logic [UNIT_W-1:0]    code_unit;
    logic                 has_char;
    logic                 end_of_string;
    logic [PARTIAL_W-1:0] partial_nxt;
    logic [EXPECT_W-1:0]  expected_nxt;
  } dec_res_t;

endpackage

/* design/u8u16_in_if.sv */
// Input channel of the decoder: one UTF-8 byte and its end-of-string flag.
// No dependencies.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

/* design/u8u16_out_if.sv */
// Result channel of the decoder: one 16-bit code unit and its flags.
// No dependencies.
interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        has_char;
  logic        end_of_string;

  modport source (output valid, output code_unit, output has_char,
                  output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input has_char,
                  input end_of_string, output ready);
endinterface

/* design/u8u16_step.sv */
// Combinational decode of one byte against the pending sequence state.
// Depends on u8u16_pkg.
module u8u16_step
  import u8u16_pkg::*;
(
  input  logic [BYTE_W-1:0]    byte_in,
  input  logic                 last_byte,
  input  logic                 null_terminated,
  input  logic [PARTIAL_W-1:0] partial,
  input  logic [EXPECT_W-1:0]  expected,
  output dec_res_t             res
);

  logic                 is_cont;
  logic                 stop_zero;
  logic [UNIT_W-1:0]    joined;
  logic [EXPECT_W-1:0]  exp_dec;
  logic                 got;
  logic [UNIT_W-1:0]    ch;
  logic [PARTIAL_W-1:0] part_n;
  logic [EXPECT_W-1:0]  exp_n;

  assign is_cont   = (byte_in & CONT_MASK) == CONT_CODE;
  assign stop_zero = null_terminated && (byte_in == '0);
  assign joined    = {partial, byte_in[5:0] & CONT_DATA[5:0]};
  assign exp_dec   = expected - EXP_ONE;

  always_comb begin
    got    = 1'b0;
    ch     = '0;
    part_n = '0;
    exp_n  = EXP_NONE;
    if (stop_zero) begin
      // Terminating zero: nothing is decoded.
    end else if ((expected != EXP_NONE) && is_cont) begin
      exp_n = exp_dec;
      if (exp_dec == EXP_NONE) begin
        got = 1'b1;
        ch  = joined;
      end else begin
        part_n = joined[PARTIAL_W-1:0];
      end
    end else if ((byte_in & ASCII_MASK) == '0) begin
      got = 1'b1;
      ch  = {{(UNIT_W-BYTE_W){1'b0}}, byte_in};
    end else if ((byte_in & LEAD2_MASK) == LEAD2_CODE) begin
      part_n = {{(PARTIAL_W-BYTE_W){1'b0}}, byte_in & LEAD2_DATA};
      exp_n  = EXP_ONE;
    end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
      part_n = {{(PARTIAL_W-BYTE_W){1'b0}}, byte_in & LEAD3_DATA};
      exp_n  = EXP_TWO;
    end

    res.has_char      = got;
    res.code_unit     = ch;
    res.end_of_string = stop_zero || last_byte;
    res.emit          = got || res.end_of_string;
    // The end of a string discards anything still pending.
    res.partial_nxt   = res.end_of_string ? '0 : part_n;
    res.expected_nxt  = res.end_of_string ? EXP_NONE : exp_n;
  end

endmodule

/* design/utf8_to_utf16_decoder_core.sv */
// Top level of the UTF-8 to UTF-16 (UCS-2) byte stream decoder.
// Depends on u8u16_pkg, u8u16_in_if, u8u16_out_if and u8u16_step.
//
//   Channel  Direction  Handshake        Contents
//   in_ch    sink       valid / ready    byte_in[7:0], last_byte
//   out_ch   source     valid / ready    code_unit[15:0], has_char, end_of_string
//   cfg_     write      cfg_we           cfg_wdata = null_terminated
//
// Each accepted byte is decoded in the cycle of its transaction and its result,
// if any, appears in the output register on the next cycle: one byte per cycle.
// The sequence state (partial value and count of continuation bytes) is updated
// at the same edge, so back-to-back bytes need no bubble.
// A stalled result holds the output register; a new byte is taken only when
// that register is empty or being emptied in the same cycle.
// Reset (rst_n, synchronous, active low) empties the output and clears the state.
module utf8_to_utf16_decoder_core
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic                 null_term_r;
  logic [PARTIAL_W-1:0] partial_r;
  logic [EXPECT_W-1:0]  expected_r;
  logic                 out_valid_r;
  logic [UNIT_W-1:0]    code_unit_r;
  logic                 has_char_r;
  logic                 eos_r;

  logic                 in_fire;
  logic                 slot_free;
  dec_res_t             dec;

  // The output register is free when empty or when its transaction completes now.
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = slot_free;
  assign in_fire     = in_ch.valid && slot_free;

  u8u16_step u_step (
    .byte_in         (in_ch.byte_in),
    .last_byte       (in_ch.last_byte),
    .null_terminated (null_term_r),
    .partial         (partial_r),
    .expected        (expected_r),
    .res             (dec)
  );

  // Control state: configuration, sequence state and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_term_r <= 1'b0;
      partial_r   <= '0;
      expected_r  <= EXP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        null_term_r <= cfg_wdata;
      end
      if (in_fire) begin
        partial_r  <= dec.partial_nxt;
        expected_r <= dec.expected_nxt;
      end
      if (slot_free) begin
        out_valid_r <= in_fire && dec.emit;
      end
    end
  end

  // Result payload is loaded only when a byte produces a result.
  always_ff @(posedge clk) begin
    if (in_fire && dec.emit) begin
      code_unit_r <= dec.code_unit;
      has_char_r  <= dec.has_char;
      eos_r       <= dec.end_of_string;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.code_unit     = code_unit_r;
  assign out_ch.has_char      = has_char_r;
  assign out_ch.end_of_string = eos_r;

endmodule

/* design/u8u16_chk.sv */
// Port-level checker for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on utf8_to_utf16_decoder_core_macros.svh.
`include "utf8_to_utf16_decoder_core_macros.svh"

module u8u16_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_code_unit,
  input logic        out_has_char,
  input logic        out_eos
);

  `U8U16_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "output valid after reset")
  `U8U16_ASSERT(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_code_unit) && $stable(out_has_char) && $stable(out_eos), "stalled result changed")
  `U8U16_ASSERT(a_no_empty_result, clk, rst_n, out_valid |-> out_has_char || out_eos, "result with neither character nor end")
  `U8U16_ASSERT(a_ascii_passes, clk, rst_n, in_valid && in_ready && !in_byte[7] && (in_byte != 8'h00) |=> out_valid && out_has_char && (out_code_unit == {8'h00, $past(in_byte)}), "ASCII byte not passed through")

endmodule

bind utf8_to_utf16_decoder_core u8u16_chk u_u8u16_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_byte       (in_ch.byte_in),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_code_unit (out_ch.code_unit),
  .out_has_char  (out_ch.has_char),
  .out_eos       (out_ch.end_of_string)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UTF-16 decoder core (utf8_to_utf16_decoder_core).
// Needs u8u16_pkg, the u8u16_in_if and u8u16_out_if channel interfaces and the core itself.
module testbench;
  import u8u16_pkg::*;

  // One byte of a string as it waits in the sender's queue.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } byte_item_t;

  // One result transaction as the decoder should deliver it.
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              has_char;
    logic              end_of_string;
  } unit_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  u8u16_in_if  in_ch ();
  u8u16_out_if out_ch ();

  utf8_to_utf16_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Bytes still to be sent and code units still to be received, both in order.
  byte_item_t pending_bytes[$];
  unit_t      expected_units[$];
  int         fail_count = 0;

  // Our own copy of the decoder state and of its single register. The state is
  // advanced once for every input transaction, at the edge that accepts it.
  logic                 nt_mode;
  logic [PARTIAL_W-1:0] partial_acc = '0;
  logic [EXPECT_W-1:0]  conts_left  = EXP_NONE;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Decodes one accepted byte, updates the state and returns 1 when the byte
  // gives rise to a result transaction, which is then placed in res.
  function automatic logic decode_utf8(input logic [BYTE_W-1:0] b, input logic last,
                                       output unit_t res);
    logic              got;
    logic              fin;
    logic [UNIT_W-1:0] ch;
    logic [UNIT_W-1:0] shifted;
    got = 1'b0;
    ch  = '0;
    if (nt_mode && b == '0) begin
      // In null-terminated mode a zero byte closes the string undecoded.
      fin = 1'b1;
    end else begin
      if (conts_left != EXP_NONE && (b & CONT_MASK) == CONT_CODE) begin
        // Continuation byte: six more payload bits move in from the right.
        shifted    = {partial_acc, b[5:0]};
        conts_left = conts_left - EXP_ONE;
        if (conts_left == EXP_NONE) begin
          partial_acc = '0;
          got         = 1'b1;
          ch          = shifted;
        end else begin
          partial_acc = shifted[PARTIAL_W-1:0];
        end
      end else begin
        // Anything else abandons a pending sequence and is decoded afresh.
        partial_acc = '0;
        conts_left  = EXP_NONE;
        if ((b & ASCII_MASK) == '0) begin
          got = 1'b1;
          ch  = {8'h00, b};
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          partial_acc = PARTIAL_W'(b & LEAD2_DATA);
          conts_left  = EXP_ONE;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
          partial_acc = PARTIAL_W'(b & LEAD3_DATA);
          conts_left  = EXP_TWO;
        end
        // Stray continuations and bytes from 0xF0 upwards simply vanish.
      end
      fin = last;
    end
    if (fin) begin
      partial_acc = '0;
      conts_left  = EXP_NONE;
    end
    res.code_unit     = got ? ch : '0;
    res.has_char      = got;
    res.end_of_string = fin;
    return got || fin;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // Monitor. Values are sampled at the rising edge before any of the edge's
  // nonblocking updates land, so both channels are seen exactly as the core saw
  // them. The result check comes first: a byte accepted at this edge cannot have
  // its result delivered at the same edge.
  always @(posedge clk) begin : watch_channels
    unit_t want;
    unit_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_units.size() == 0) begin
          report_mismatch("result transaction with nothing expected",
                          int'(out_ch.code_unit), 0);
        end else begin
          want = expected_units.pop_front();
          if (out_ch.code_unit !== want.code_unit)
            report_mismatch("code_unit", int'(out_ch.code_unit), int'(want.code_unit));
          if (out_ch.has_char !== want.has_char)
            report_mismatch("has_char", int'(out_ch.has_char), int'(want.has_char));
          if (out_ch.end_of_string !== want.end_of_string)
            report_mismatch("end_of_string", int'(out_ch.end_of_string),
                            int'(want.end_of_string));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (decode_utf8(in_ch.byte_in, in_ch.last_byte, pred))
          expected_units.push_back(pred);
      end
    end
  end

  // Sender. Bytes go out in bursts of random length; between bursts there is
  // a random gap, and about a third of the gaps are empty so that long
  // back-to-back stretches also occur. A new byte is presented only once the
  // previous one has been taken, so valid is assigned once per edge at most.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_bytes
    byte_item_t next_byte;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.byte_in   <= '0;
      in_ch.last_byte <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        next_byte = pending_bytes.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.byte_in   <= next_byte.value;
        in_ch.last_byte <= next_byte.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver. Ready follows a repeating 16-bit pattern that is itself redrawn at random:
  // sometimes always ready, sometimes dense or sparse stalls. A pattern always
  // has at least one ready cycle in it, so no stall outlasts one pass of the pattern.
  logic [15:0] ready_pattern = 16'hffff;
  int          ready_tick    = 0;

  always @(posedge clk) begin : drive_ready
    if (ready_tick % 64 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 16'hffff;
        1:       ready_pattern = 16'($urandom) | 16'h0001;
        2:       ready_pattern = 16'($urandom & $urandom) | 16'h0001;
        default: ready_pattern = 16'($urandom | $urandom) | 16'h0001;
      endcase
    end
    out_ch.ready <= ready_pattern[4'(ready_tick % 16)];
    ready_tick++;
  end

  function automatic logic [BYTE_W-1:0] rnd_byte(input logic [BYTE_W-1:0] lo,
                                                 input logic [BYTE_W-1:0] hi);
    return BYTE_W'($urandom_range(hi, lo));
  endfunction

  task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
    byte_item_t item;
    item.value = b;
    item.last  = last;
    pending_bytes.push_back(item);
  endtask

  // Writes the null_terminated register. Only called while the core is idle,
  // so our own copy can follow at once.
  task automatic write_mode(input logic nt);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= nt;
    nt_mode = nt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every byte has been sent and every result received, sampling on
  // the falling edge where all signals are settled, and then lets a byte that
  // produced no result settle as well. The guard keeps a lost result from hanging
  // the run here; it is reported at the end instead.
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((pending_bytes.size() != 0 || in_ch.valid || expected_units.size() != 0) &&
           guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Builds random strings until n_bytes bytes are queued. Strings are built from
  // random elements, mostly well-formed characters; the rest are cut-off sequences,
  // stray continuations, bytes from 0xF0 upwards, raw noise and zero bytes. A string
  // ends on its flagged last byte or, in null-terminated mode, on a zero byte.
  task automatic queue_random_strings(input int n_bytes);
    logic [BYTE_W-1:0] text[$];
    int                added;
    int                roll;
    added = 0;
    while (added < n_bytes) begin
      text.delete();
      repeat ($urandom_range(1, 12)) begin
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
          text.push_back(rnd_byte(8'h01, 8'h7f));
        end else if (roll < 55) begin
          text.push_back(rnd_byte(LEAD2_CODE, LEAD2_CODE | LEAD2_DATA));
          text.push_back(rnd_byte(CONT_CODE, CONT_CODE | CONT_DATA));
        end else if (roll < 75) begin
          text.push_back(rnd_byte(LEAD3_CODE, LEAD3_CODE | LEAD3_DATA));
          text.push_back(rnd_byte(CONT_CODE, CONT_CODE | CONT_DATA));
          text.push_back(rnd_byte(CONT_CODE, CONT_CODE | CONT_DATA));
        end else if (roll < 80) begin
          // A sequence that stops short of its last continuation byte.
          if ($urandom_range(0, 1)) begin
            text.push_back(rnd_byte(LEAD2_CODE, LEAD2_CODE | LEAD2_DATA));
          end else begin
            text.push_back(rnd_byte(LEAD3_CODE, LEAD3_CODE | LEAD3_DATA));
            if ($urandom_range(0, 1))
              text.push_back(rnd_byte(CONT_CODE, CONT_CODE | CONT_DATA));
          end
        end else if (roll < 85) begin
          text.push_back(rnd_byte(CONT_CODE, CONT_CODE | CONT_DATA));
        end else if (roll < 90) begin
          text.push_back(rnd_byte(8'hf0, 8'hff));
        end else if (roll < 95) begin
          text.push_back(rnd_byte(8'h00, 8'hff));
        end else begin
          text.push_back(8'h00);
        end
      end
      if (nt_mode && $urandom_range(0, 1)) begin
        foreach (text[i]) queue_byte(text[i], 1'b0);
        queue_byte(8'h00, $urandom_range(0, 3) == 0);
        added += text.size() + 1;
      end else begin
        foreach (text[i]) queue_byte(text[i], i == text.size() - 1);
        added += text.size();
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    nt_mode   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed string in plain mode: a zero byte as character 0, the largest
    // one-byte character, the smallest and largest two-byte characters, an
    // overlong three-byte form, 0xFFFF, a surrogate value, a stray continuation,
    // 0xFF, a two-byte lead broken by an ASCII byte, a lead byte flagged as last
    // (end marker only) and a character flagged as last.
    write_mode(1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'hc2, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hdf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'he0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hef, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hed, 1'b0);
    queue_byte(8'ha0, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hc3, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'he4, 1'b1);
    queue_byte(8'h5a, 1'b1);
    wait_idle();

    // Directed strings in null-terminated mode: a zero byte cutting off a
    // pending lead, then a zero terminator that is also flagged as last.
    write_mode(1'b1);
    queue_byte(8'he2, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h00, 1'b1);
    wait_idle();

    // Random phases, switching the register between its two values.
    for (int phase = 0; phase < 6; phase++) begin
      write_mode(phase % 2 == 1);
      queue_random_strings(155);
      wait_idle();
    end

    if (expected_units.size() != 0)
      report_mismatch("results never delivered", expected_units.size(), 0);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/u8u16_pkg.sv
design/u8u16_in_if.sv
design/u8u16_out_if.sv
design/u8u16_step.sv
design/utf8_to_utf16_decoder_core.sv
design/u8u16_chk.sv
tb/testbench.sv
